>>> design/ftmc_pkg.sv
// ---------------------------------------------------------------------------
// ftmc_pkg
// Shared types and constants for the fermion term mask compiler: operator
// codes, term status codes and the decoded command passed front to back.
// ---------------------------------------------------------------------------
`default_nettype none

package ftmc_pkg;

  // lattice geometry and mask width
  localparam int NUM_SITES   = 32;
  localparam int SITE_W      = 5;
  localparam int MASK_W      = 64;

  // depth of the command queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // operator codes on the input side
  typedef enum logic [2:0] {
    OP_NUP     = 3'd0,
    OP_NDN     = 3'd1,
    OP_NUPDN   = 3'd2,
    OP_CUP     = 3'd3,
    OP_CDAGUP  = 3'd4,
    OP_CDN     = 3'd5,
    OP_CDAGDN  = 3'd6,
    OP_UNKNOWN = 3'd7
  } op_t;

  // term status codes on the result side
  typedef enum logic [1:0] {
    ST_VALID = 2'd0,
    ST_DEAD  = 2'd1,
    ST_ERROR = 2'd2
  } status_t;

  // decoded factor command
  typedef struct packed {
    logic                  op_ok;      // known code and site in range
    logic                  clear_req;  // creator: bit must be clear
    logic                  ladder;     // toggles its bit and feeds the sign
    logic                  use_up;     // acts on the spin-up bit
    logic                  use_dn;     // acts on the spin-down bit
    logic [SITE_W-1:0]     site;
    logic                  last;       // final factor of the term
  } cmd_t;

endpackage

`default_nettype wire

>>> design/ftmc_front.sv
// ---------------------------------------------------------------------------
// ftmc_front
// Input side: takes factor transactions and classifies each operator code
// and site into a command for the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module ftmc_front (
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [7:0]                  s_tdata,   // [4:0] site_index
  input  wire logic [2:0]                  s_tuser,   // [2:0] req_type
  input  wire logic                        s_tlast,   // last_factor
  input  wire logic                        q_full,
  output logic                             q_push,
  output ftmc_pkg::cmd_t                   q_cmd
);

  logic [ftmc_pkg::SITE_W-1:0] site;
  logic                        site_ok;

  assign site    = s_tdata[ftmc_pkg::SITE_W-1:0];
  assign site_ok = ({1'b0, site} < (ftmc_pkg::SITE_W+1)'(ftmc_pkg::NUM_SITES));

  // handshake toward the queue
  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;

  // operator classification
  always_comb begin
    q_cmd           = '0;
    q_cmd.site      = site;
    q_cmd.last      = s_tlast;
    q_cmd.op_ok     = site_ok;
    case (ftmc_pkg::op_t'(s_tuser))
      ftmc_pkg::OP_NUP: begin
        q_cmd.use_up = 1'b1;
      end
      ftmc_pkg::OP_NDN: begin
        q_cmd.use_dn = 1'b1;
      end
      ftmc_pkg::OP_NUPDN: begin
        q_cmd.use_up = 1'b1;
        q_cmd.use_dn = 1'b1;
      end
      ftmc_pkg::OP_CUP: begin
        q_cmd.use_up = 1'b1;
        q_cmd.ladder = 1'b1;
      end
      ftmc_pkg::OP_CDAGUP: begin
        q_cmd.use_up    = 1'b1;
        q_cmd.ladder    = 1'b1;
        q_cmd.clear_req = 1'b1;
      end
      ftmc_pkg::OP_CDN: begin
        q_cmd.use_dn = 1'b1;
        q_cmd.ladder = 1'b1;
      end
      ftmc_pkg::OP_CDAGDN: begin
        q_cmd.use_dn    = 1'b1;
        q_cmd.ladder    = 1'b1;
        q_cmd.clear_req = 1'b1;
      end
      default: begin
        q_cmd.op_ok = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> design/ftmc_queue.sv
// ---------------------------------------------------------------------------
// ftmc_queue
// Short command queue between front and back so each side can stall on
// its own.
// ---------------------------------------------------------------------------
`default_nettype none

module ftmc_queue #(
  parameter int DEPTH = ftmc_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire ftmc_pkg::cmd_t push_cmd,
  output logic                full,
  input  wire logic           pop,
  output logic                not_empty,
  output ftmc_pkg::cmd_t      head_cmd
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ftmc_pkg::cmd_t    entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign head_cmd  = entries[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> design/ftmc_back.sv
// ---------------------------------------------------------------------------
// ftmc_back
// Execution side: folds queued commands into the four term masks and
// registers the finished term on the result channel.
// ---------------------------------------------------------------------------
`default_nettype none

module ftmc_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_valid,
  input  wire ftmc_pkg::cmd_t q_cmd,
  output logic                q_pop,
  output logic                m_tvalid,
  input  wire logic           m_tready,
  output logic [255:0]        m_tdata,  // check, required, toggle, parity
  output logic [1:0]          m_tuser   // [1:0] term_status
);

  localparam int MW = ftmc_pkg::MASK_W;

  logic [MW-1:0] acc_check;
  logic [MW-1:0] acc_required;
  logic [MW-1:0] acc_toggle;
  logic [MW-1:0] acc_parity;
  logic          term_alive;
  logic          term_error;

  logic [MW-1:0] acc_check_next;
  logic [MW-1:0] acc_required_next;
  logic [MW-1:0] acc_toggle_next;
  logic [MW-1:0] acc_parity_next;
  logic          term_alive_next;
  logic          term_error_next;

  logic [MW-1:0] up_bit;
  logic [MW-1:0] bits;
  logic          conflict;
  logic          out_free;
  ftmc_pkg::status_t status;

  // a last factor waits while the result register is still held
  assign out_free = !m_tvalid || m_tready;
  assign q_pop    = q_valid && (!q_cmd.last || out_free);

  // bit selection for the factor
  assign up_bit = MW'(1) << {q_cmd.site, 1'b0};
  assign bits   = (q_cmd.use_up ? up_bit : '0) | (q_cmd.use_dn ? (up_bit << 1) : '0);

  // requirement conflict against earlier factors
  assign conflict = q_cmd.clear_req ? |(acc_check & bits & acc_required)
                                    : |(acc_check & bits & ~acc_required);

  // factor update
  always_comb begin
    acc_check_next    = acc_check;
    acc_required_next = acc_required;
    acc_toggle_next   = acc_toggle;
    acc_parity_next   = acc_parity;
    term_alive_next   = term_alive;
    term_error_next   = term_error;
    if (term_alive && !term_error) begin
      if (!q_cmd.op_ok) begin
        term_error_next = 1'b1;
      end else if (conflict) begin
        term_alive_next = 1'b0;
      end else begin
        acc_check_next    = acc_check | bits;
        acc_required_next = q_cmd.clear_req ? (acc_required & ~bits) : (acc_required | bits);
        if (q_cmd.ladder) begin
          acc_toggle_next = acc_toggle ^ bits;
          acc_parity_next = acc_parity ^ (bits - MW'(1));
        end
      end
    end
  end

  // status of the finished term, error ahead of annihilation
  always_comb begin
    if (term_error_next) begin
      status = ftmc_pkg::ST_ERROR;
    end else if (!term_alive_next) begin
      status = ftmc_pkg::ST_DEAD;
    end else begin
      status = ftmc_pkg::ST_VALID;
    end
  end

  // accumulators, cleared after the last factor
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_check    <= '0;
      acc_required <= '0;
      acc_toggle   <= '0;
      acc_parity   <= '0;
      term_alive   <= 1'b1;
      term_error   <= 1'b0;
    end else if (q_pop) begin
      if (q_cmd.last) begin
        acc_check    <= '0;
        acc_required <= '0;
        acc_toggle   <= '0;
        acc_parity   <= '0;
        term_alive   <= 1'b1;
        term_error   <= 1'b0;
      end else begin
        acc_check    <= acc_check_next;
        acc_required <= acc_required_next;
        acc_toggle   <= acc_toggle_next;
        acc_parity   <= acc_parity_next;
        term_alive   <= term_alive_next;
        term_error   <= term_error_next;
      end
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (q_pop && q_cmd.last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // result payload, masks zeroed for a failed term
  always_ff @(posedge clk) begin
    if (q_pop && q_cmd.last) begin
      m_tuser <= 2'(status);
      if (status == ftmc_pkg::ST_VALID) begin
        m_tdata <= {acc_parity_next, acc_toggle_next, acc_required_next, acc_check_next};
      end else begin
        m_tdata <= '0;
      end
    end
  end

endmodule

`default_nettype wire

>>> design/fermion_term_mask_compiler.sv
// ---------------------------------------------------------------------------
// fermion_term_mask_compiler
// Folds the factors of one fermionic operator term into check, required,
// toggle and parity masks and emits one result per term.
// ---------------------------------------------------------------------------
//
//  channel  | dir | tdata                                  | tuser       | tlast
//  ---------+-----+----------------------------------------+-------------+------------
//  s_*      | in  | [4:0] site_index                       | req_type    | last_factor
//  m_*      | out | check, required, toggle, parity (64 ea) | term_status | -
//
//  one factor per cycle while the queue has room; a taken last factor passes
//  the queue entry, then the back-end result register, before its result leaves.
//  the four-entry command queue lets the front keep taking factors while a
//  result waits on m_tready; only a last factor stalls behind a held result.
//  synchronous reset clears the queue and returns the term to empty and live.
// ---------------------------------------------------------------------------
`default_nettype none

module fermion_term_mask_compiler #(
  parameter int QUEUE_DEPTH = ftmc_pkg::QUEUE_DEPTH
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [7:0]   s_tdata,   // [4:0] site_index
  input  wire logic [2:0]   s_tuser,   // [2:0] req_type
  input  wire logic         s_tlast,   // last_factor
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [255:0]      m_tdata,   // [63:0] check_bits, [127:64] required_bits,
                                       // [191:128] toggle_bits, [255:192] parity_bits
  output logic [1:0]        m_tuser    // [1:0] term_status
);

  logic           q_full;
  logic           q_push;
  logic           q_pop;
  logic           q_valid;
  ftmc_pkg::cmd_t push_cmd;
  ftmc_pkg::cmd_t head_cmd;

  // factor classification
  ftmc_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  // command queue
  ftmc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head_cmd  (head_cmd)
  );

  // mask accumulation and result register
  ftmc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_cmd    (head_cmd),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire
